// File: src/jhs_pkg.sv
// ---------------------------------------------------------------------------
// jhs_pkg - shared types, constants and helpers of the heat sweep unit
// Lattice limits, register codes, result word layout and post geometry.
// ---------------------------------------------------------------------------
package jhs_pkg;

   // lattice and number format
   localparam int MAX_ROWS   = 1024;
   localparam int MAX_COLS   = 1024;
   localparam int POST_SIZE  = 10;
   localparam int TEMP_BITS  = 16;

   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int DIM_W      = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
   localparam int OUT_POS_W  = 10;
   localparam int SUM_W      = TEMP_BITS + 2;

   // configuration port
   localparam int CFG_SIZE_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = (TEMP_BITS > CFG_SIZE_W) ? TEMP_BITS : CFG_SIZE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS     = 3'd0,
      CSR_GRID_COLS     = 3'd1,
      CSR_EDGE_ROW_TEMP = 3'd2,
      CSR_SIDE_TEMP     = 3'd3,
      CSR_POST_TEMP     = 3'd4
   } csr_index_type;

   localparam int RESET_ROWS      = 1000;
   localparam int RESET_COLS      = 1000;
   localparam int RESET_EDGE_TEMP = 5120;
   localparam int RESET_SIDE_TEMP = 23040;
   localparam int RESET_POST_TEMP = 2560;

   // floor(n / 3) as (n * RECIP) >> SHIFT, exact for n below 2**15
   localparam int RECIP_SHIFT = 16;
   localparam int THIRD_RECIP = ((1 << RECIP_SHIFT) + 2) / 3;
   localparam int POST_HALF   = POST_SIZE / 2;

   // result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // one lattice dimension, pre-decoded at write time
   typedef struct packed {
      logic [DIM_W-1:0] last;   // effective size minus one
      logic [DIM_W-1:0] lo1;    // first post span, inclusive low
      logic [DIM_W-1:0] hi1;    // first post span, exclusive high
      logic [DIM_W-1:0] lo2;
      logic [DIM_W-1:0] hi2;
   } dim_type;

   typedef struct packed {
      dim_type                rows;
      dim_type                cols;
      logic [TEMP_BITS-1:0]   edge_row_temp;
      logic [TEMP_BITS-1:0]   side_temp;
      logic [TEMP_BITS-1:0]   post_temp;
   } cfg_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0] out_row;
      logic [OUT_POS_W-1:0] out_col;
      logic [TEMP_BITS-1:0] new_temp;
      logic                 run_last;
      logic                 sweep_done;
   } res_type;

   typedef struct packed {
      logic emit_prev;    // a word for the row above is produced
      logic last_row;     // a word for this row is produced as well
      logic end_of_row;
      logic row_wrap;     // row counter returns to zero at end of row
   } step_type;

   function automatic logic [DIM_W-1:0] post_lo(input logic [DIM_W-1:0] centre);
      logic [DIM_W-1:0] lo;
      lo = (centre >= DIM_W'(POST_HALF)) ? centre - DIM_W'(POST_HALF) : '0;
      return lo;
   endfunction

   function automatic logic [DIM_W-1:0] post_hi(input logic [DIM_W-1:0] centre);
      logic [DIM_W-1:0] hi;
      hi = centre + DIM_W'(POST_SIZE - POST_HALF);
      return hi;
   endfunction

   function automatic dim_type make_dim(input logic [CFG_SIZE_W-1:0] raw,
                                        input int                    maxv);
      logic [DIM_W-1:0]             eff;
      logic [DIM_W+RECIP_SHIFT:0]   p1;
      logic [DIM_W+RECIP_SHIFT:0]   p2;
      logic [DIM_W-1:0]             c1;
      logic [DIM_W-1:0]             c2;
      dim_type                      d;
      if (raw == '0) begin
         eff = DIM_W'(1);
      end else if (int'(raw) > maxv) begin
         eff = DIM_W'(maxv);
      end else begin
         eff = DIM_W'(raw);
      end
      p1 = (DIM_W+RECIP_SHIFT+1)'(eff) * (DIM_W+RECIP_SHIFT+1)'(THIRD_RECIP);
      p2 = (DIM_W+RECIP_SHIFT+1)'({eff, 1'b0}) * (DIM_W+RECIP_SHIFT+1)'(THIRD_RECIP);
      c1 = DIM_W'(p1 >> RECIP_SHIFT);
      c2 = DIM_W'(p2 >> RECIP_SHIFT);
      d.last = eff - DIM_W'(1);
      d.lo1  = post_lo(c1);
      d.hi1  = post_hi(c1);
      d.lo2  = post_lo(c2);
      d.hi2  = post_hi(c2);
      return d;
   endfunction

   function automatic logic in_span(input logic [DIM_W-1:0] pos,
                                    input logic [DIM_W-1:0] lo,
                                    input logic [DIM_W-1:0] hi);
      return (pos >= lo) && (pos < hi);
   endfunction

endpackage

// File: src/jacobi_heat_sweep_unit.sv
// ---------------------------------------------------------------------------
// jacobi_heat_sweep_unit - one Jacobi sweep of a four-neighbour heat stencil
// Streams the old lattice in raster order and the new lattice out one row
// behind, with row and column of every word.
// ---------------------------------------------------------------------------
// Feed one Q8.8 cell temperature per req word in raster order; the unit
// keeps the two most recent rows in a pair of row banks and returns the new
// value of the cell directly above each incoming cell (so row 0 returns
// nothing). In the last row every input word also returns its own cell,
// which is always a boundary value, so two rsp words leave for that input.
// Interior cells become the truncated quarter of north + south + west + east;
// posts take post_temp, columns 0 and last take side_temp, rows 0 and last
// take edge_row_temp, in that order of priority. Rate: one req word per
// cycle while req_stall is low on every row but the last, where the single
// rsp word per cycle sets the pace, as each input there makes two; a
// four-word result queue absorbs the difference and req_stall rises when it
// cannot take two more words. A result is queued as its input is accepted.
// The row banks are not cleared after reset and there is no clearing pass:
// the first row of a sweep is all boundary, so no stale entry is ever used.
// Write the csr registers only while no words are in flight.
// ---------------------------------------------------------------------------
module jacobi_heat_sweep_unit
   import jhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input cell stream
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TEMP_BITS-1:0]  req_cell_temp,
   // result stream
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_POS_W-1:0]  rsp_out_row,
   output logic [OUT_POS_W-1:0]  rsp_out_col,
   output logic [TEMP_BITS-1:0]  rsp_new_temp,
   output logic                  rsp_run_last,
   output logic                  rsp_sweep_done,
   // configuration writes
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type              cfg;
   step_type             step;
   res_type              res_a;
   res_type              res_b;
   res_type              head;
   logic                 q_not_empty;
   logic                 q_room_for_two;
   logic                 req_accept;
   logic                 rsp_accept;

   logic [ROW_W-1:0]     row_count_ff;
   logic [ROW_W-1:0]     row_count_in;
   logic [COL_W-1:0]     col_count_ff;
   logic [COL_W-1:0]     col_count_in;

   logic [COL_W-1:0]     rd_addr_a [2];
   logic [COL_W-1:0]     rd_addr_b [2];
   logic [TEMP_BITS-1:0] rd_data_a [2];
   logic [TEMP_BITS-1:0] rd_data_b [2];
   logic [TEMP_BITS-1:0] north;
   logic [TEMP_BITS-1:0] west;
   logic [TEMP_BITS-1:0] east_raw;

   jhs_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   assign req_stall  = !q_room_for_two;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // Advance the raster position on every accepted word; a counter at or
   // past the size wraps at the end of its step.
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (req_accept) begin
         if (step.end_of_row) begin
            col_count_in = '0;
            row_count_in = step.row_wrap ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // Row banks. Bank (row & 1) holds row r-2, read as north at the cell's
   // column and then overwritten by the incoming cell; the other bank holds
   // row r-1, read at both neighbouring columns. Reads are issued for the
   // next raster position so the registered data is there when it arrives.
   for (genvar b = 0; b < 2; b++) begin : g_bank
      assign rd_addr_a[b] = (row_count_in[0] == 1'(b)) ? col_count_in
                                                       : col_count_in - COL_W'(1);
      assign rd_addr_b[b] = col_count_in + COL_W'(1);

      jhs_ram #(
         .WIDTH (TEMP_BITS),
         .DEPTH (MAX_COLS)
      ) u_row_bank (
         .clock     (clock),
         .wr_en     (req_accept && (row_count_ff[0] == 1'(b))),
         .wr_addr   (col_count_ff),
         .wr_data   (req_cell_temp),
         .rd_addr_a (rd_addr_a[b]),
         .rd_addr_b (rd_addr_b[b]),
         .rd_data_a (rd_data_a[b]),
         .rd_data_b (rd_data_b[b])
      );
   end

   // Steer bank outputs by the bank the current row writes into.
   assign north    = row_count_ff[0] ? rd_data_a[1] : rd_data_a[0];
   assign west     = row_count_ff[0] ? rd_data_a[0] : rd_data_a[1];
   assign east_raw = row_count_ff[0] ? rd_data_b[0] : rd_data_b[1];

   jhs_stencil u_stencil (
      .cfg      (cfg),
      .row_cnt  (row_count_ff),
      .col_cnt  (col_count_ff),
      .south    (req_cell_temp),
      .north    (north),
      .west     (west),
      .east_raw (east_raw),
      .step     (step),
      .res_a    (res_a),
      .res_b    (res_b)
   );

   // The word for the row above goes first, then the last-row word.
   jhs_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push_a       (req_accept && step.emit_prev),
      .word_a       (res_a),
      .push_b       (req_accept && step.last_row),
      .word_b       (res_b),
      .pop          (rsp_accept),
      .head         (head),
      .not_empty    (q_not_empty),
      .room_for_two (q_room_for_two)
   );

   assign rsp_valid      = q_not_empty;
   assign rsp_out_row    = head.out_row;
   assign rsp_out_col    = head.out_col;
   assign rsp_new_temp   = head.new_temp;
   assign rsp_run_last   = head.run_last;
   assign rsp_sweep_done = head.sweep_done;

   col_advance: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !step.end_of_row) |=>
         (col_count_ff == COL_W'($past(col_count_ff) + COL_W'(1))))
      else $error("column counter failed to advance");

   position_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(row_count_ff) && $stable(col_count_ff)))
      else $error("raster position moved without an accepted word");

   done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sweep_done) |-> rsp_run_last)
      else $error("sweep end flagged on a word that is not the last of its input");

endmodule

// File: src/jhs_ram.sv
// ---------------------------------------------------------------------------
// jhs_ram - generic RAM, one write port, two registered read ports
// Read returns the old contents when the same address is written.
// ---------------------------------------------------------------------------
module jhs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: src/jhs_cfg.sv
// ---------------------------------------------------------------------------
// jhs_cfg - configuration registers
// Clamp the lattice sizes and pre-decode post spans as each size is written.
// ---------------------------------------------------------------------------
module jhs_cfg
   import jhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_ROWS:     cfg_in.rows = make_dim(csr_wdata[CFG_SIZE_W-1:0], MAX_ROWS);
            CSR_GRID_COLS:     cfg_in.cols = make_dim(csr_wdata[CFG_SIZE_W-1:0], MAX_COLS);
            CSR_EDGE_ROW_TEMP: cfg_in.edge_row_temp = csr_wdata[TEMP_BITS-1:0];
            CSR_SIDE_TEMP:     cfg_in.side_temp = csr_wdata[TEMP_BITS-1:0];
            CSR_POST_TEMP:     cfg_in.post_temp = csr_wdata[TEMP_BITS-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows          <= make_dim(CFG_SIZE_W'(RESET_ROWS), MAX_ROWS);
         cfg_ff.cols          <= make_dim(CFG_SIZE_W'(RESET_COLS), MAX_COLS);
         cfg_ff.edge_row_temp <= TEMP_BITS'(RESET_EDGE_TEMP);
         cfg_ff.side_temp     <= TEMP_BITS'(RESET_SIDE_TEMP);
         cfg_ff.post_temp     <= TEMP_BITS'(RESET_POST_TEMP);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/jhs_stencil.sv
// ---------------------------------------------------------------------------
// jhs_stencil - boundary rules and four-neighbour average
// Form up to two result words for the cell at the current raster position.
// ---------------------------------------------------------------------------
module jhs_stencil
   import jhs_pkg::*;
(
   input  cfg_type              cfg,
   input  logic [ROW_W-1:0]     row_cnt,
   input  logic [COL_W-1:0]     col_cnt,
   input  logic [TEMP_BITS-1:0] south,
   input  logic [TEMP_BITS-1:0] north,
   input  logic [TEMP_BITS-1:0] west,
   input  logic [TEMP_BITS-1:0] east_raw,
   output step_type             step,
   output res_type              res_a,
   output res_type              res_b
);

   typedef enum logic [1:0] {
      RULE_INTERIOR,
      RULE_POST,
      RULE_SIDE,
      RULE_EDGE
   } rule_type;

   // posts win over sides, sides over top and bottom rows
   function automatic rule_type cell_rule(input logic [ROW_W-1:0] p,
                                          input logic [COL_W-1:0] q,
                                          input cfg_type          c);
      logic     rin;
      logic     cin;
      rule_type rule;
      rin = in_span(DIM_W'(p), c.rows.lo1, c.rows.hi1) ||
            in_span(DIM_W'(p), c.rows.lo2, c.rows.hi2);
      cin = in_span(DIM_W'(q), c.cols.lo1, c.cols.hi1) ||
            in_span(DIM_W'(q), c.cols.lo2, c.cols.hi2);
      if (rin && cin) begin
         rule = RULE_POST;
      end else if ((q == '0) || (DIM_W'(q) == c.cols.last)) begin
         rule = RULE_SIDE;
      end else if ((p == '0) || (DIM_W'(p) == c.rows.last)) begin
         rule = RULE_EDGE;
      end else begin
         rule = RULE_INTERIOR;
      end
      return rule;
   endfunction

   logic [ROW_W-1:0]     prev_row;
   logic [TEMP_BITS-1:0] east;
   logic [SUM_W-1:0]     sum;
   logic [TEMP_BITS-1:0] avg;
   rule_type             rule_a;
   rule_type             rule_b;
   logic [TEMP_BITS-1:0] temp_a;
   logic [TEMP_BITS-1:0] temp_b;

   assign prev_row = row_cnt - ROW_W'(1);

   // the store holds no column beyond the widest row: read it as zero
   assign east = (col_cnt == COL_W'(MAX_COLS - 1)) ? '0 : east_raw;

   assign sum = SUM_W'(north) + SUM_W'(west) + SUM_W'(east) + SUM_W'(south);
   assign avg = sum[SUM_W-1:2];

   assign rule_a = cell_rule(prev_row, col_cnt, cfg);
   assign rule_b = cell_rule(row_cnt, col_cnt, cfg);

   always_comb begin
      case (rule_a)
         RULE_POST: temp_a = cfg.post_temp;
         RULE_SIDE: temp_a = cfg.side_temp;
         RULE_EDGE: temp_a = cfg.edge_row_temp;
         default:   temp_a = avg;
      endcase
      case (rule_b)
         RULE_POST: temp_b = cfg.post_temp;
         RULE_SIDE: temp_b = cfg.side_temp;
         default:   temp_b = cfg.edge_row_temp;
      endcase
   end

   assign step.emit_prev  = (row_cnt != '0);
   assign step.last_row   = (DIM_W'(row_cnt) == cfg.rows.last);
   assign step.end_of_row = (DIM_W'(col_cnt) >= cfg.cols.last);
   assign step.row_wrap   = (DIM_W'(row_cnt) >= cfg.rows.last);

   assign res_a.out_row    = OUT_POS_W'(prev_row);
   assign res_a.out_col    = OUT_POS_W'(col_cnt);
   assign res_a.new_temp   = temp_a;
   assign res_a.run_last   = !step.last_row;
   assign res_a.sweep_done = 1'b0;

   assign res_b.out_row    = OUT_POS_W'(row_cnt);
   assign res_b.out_col    = OUT_POS_W'(col_cnt);
   assign res_b.new_temp   = temp_b;
   assign res_b.run_last   = 1'b1;
   assign res_b.sweep_done = step.end_of_row;

endmodule

// File: src/jhs_rsp_queue.sv
// ---------------------------------------------------------------------------
// jhs_rsp_queue - small result queue, up to two pushes and one pop a cycle
// Parts the input side from the result channel.
// ---------------------------------------------------------------------------
module jhs_rsp_queue
   import jhs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_a,
   input  res_type word_a,
   input  logic    push_b,
   input  res_type word_b,
   input  logic    pop,
   output res_type head,
   output logic    not_empty,
   output logic    room_for_two
);

   res_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] q_count_ff;
   logic [QCNT_W-1:0] q_count_in;
   logic [QCNT_W-1:0] n_push;
   res_type           first_word;

   assign first_word = push_a ? word_a : word_b;
   assign n_push     = QCNT_W'(push_a) + QCNT_W'(push_b);

   assign wr_ptr_in  = wr_ptr_ff + QPTR_W'(n_push);
   assign rd_ptr_in  = rd_ptr_ff + QPTR_W'(pop);
   assign q_count_in = q_count_ff + n_push - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_a || push_b) begin
         q_ff[wr_ptr_ff] <= first_word;
      end
      if (push_a && push_b) begin
         q_ff[wr_ptr_ff + QPTR_W'(1)] <= word_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   assign head         = q_ff[rd_ptr_ff];
   assign not_empty    = (q_count_ff != '0);
   assign room_for_two = (q_count_ff <= QCNT_W'(QDEPTH - 2));

   occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overfilled");

   double_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_a && push_b) |-> (q_count_ff <= QCNT_W'(QDEPTH - 2)))
      else $error("two words pushed without room");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - self-checking bench for the Jacobi heat sweep unit
// Streams whole lattice sweeps of Q8.8 cell temperatures through the unit.
// An independent stencil predictor works out every new-cell word, which is
// checked in order and field by field. Bursty input, patterned output
// stalls, a long receiver hold-off and mid-sweep drains load the queue.
// ---------------------------------------------------------------------------
module testbench;
   import jhs_pkg::*;

   localparam int IDLE_LIMIT    = 2000;   // cycles with no handshake at all
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int RANDOM_CELLS  = 190;
   localparam int PARTIAL_CELLS = 32;     // cells sent into an oversized lattice
   localparam int SETTLE        = 4;      // unit latency plus margin

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_type;

   // -----------------------------------------------------------------------
   // unit under test and its stimulus, all known from time zero
   // -----------------------------------------------------------------------
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [TEMP_BITS-1:0]  req_cell_temp  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [OUT_POS_W-1:0]  rsp_out_row;
   logic [OUT_POS_W-1:0]  rsp_out_col;
   logic [TEMP_BITS-1:0]  rsp_new_temp;
   logic                  rsp_run_last;
   logic                  rsp_sweep_done;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   jacobi_heat_sweep_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_temp  (req_cell_temp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_new_temp   (rsp_new_temp),
      .rsp_run_last   (rsp_run_last),
      .rsp_sweep_done (rsp_sweep_done),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -----------------------------------------------------------------------
   // stencil predictor: own copy of the registers, row banks and position
   // -----------------------------------------------------------------------
   logic [CFG_SIZE_W-1:0] rows_reg     = CFG_SIZE_W'(RESET_ROWS);
   logic [CFG_SIZE_W-1:0] cols_reg     = CFG_SIZE_W'(RESET_COLS);
   logic [TEMP_BITS-1:0]  edge_row_reg = TEMP_BITS'(RESET_EDGE_TEMP);
   logic [TEMP_BITS-1:0]  side_reg     = TEMP_BITS'(RESET_SIDE_TEMP);
   logic [TEMP_BITS-1:0]  post_reg     = TEMP_BITS'(RESET_POST_TEMP);

   logic [TEMP_BITS-1:0]  heat_bank [2][MAX_COLS];
   int                    next_row = 0;
   int                    next_col = 0;

   // new-cell words still owed by the unit, oldest first
   res_type               expected_cells [$];

   // run bookkeeping
   int                    error_count   = 0;
   int                    cells_sent    = 0;
   int                    words_checked = 0;
   int                    sweeps_seen   = 0;
   int                    random_cells  = 0;

   // sender pacing and receiver hold-off request
   bit                    sender_steady = 1'b0;
   int                    burst_left    = 0;
   int                    hold_request  = 0;

   function automatic int clamp_dim(input logic [CFG_SIZE_W-1:0] raw, input int maxv);
      if (raw == '0) return 1;
      return (int'(raw) > maxv) ? maxv : int'(raw);
   endfunction

   // a post spans POST_SIZE cells starting half a post before its centre
   function automatic bit near_centre(input int pos, input int centre);
      int lo;
      lo = centre - POST_SIZE / 2;
      return (pos >= lo) && (pos < lo + POST_SIZE);
   endfunction

   // fixed value of a boundary cell; posts beat sides, sides beat top and bottom
   function automatic bit boundary_temp(input int r, input int c, input int nr, input int nc,
                                        output logic [TEMP_BITS-1:0] t);
      bit row_hit;
      bit col_hit;
      row_hit = near_centre(r, nr / 3) || near_centre(r, (2 * nr) / 3);
      col_hit = near_centre(c, nc / 3) || near_centre(c, (2 * nc) / 3);
      t = '0;
      if (row_hit && col_hit) begin
         t = post_reg;
         return 1'b1;
      end
      if (c == 0 || c == nc - 1) begin
         t = side_reg;
         return 1'b1;
      end
      if (r == 0 || r == nr - 1) begin
         t = edge_row_reg;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [TEMP_BITS-1:0] bank_read(input int row, input int col);
      if (col >= MAX_COLS) return '0;
      return heat_bank[row & 1][col];
   endfunction

   function automatic res_type heat_word(input int r, input int c, input logic [TEMP_BITS-1:0] t,
                                         input bit run_last, input bit done);
      res_type w;
      w.out_row    = OUT_POS_W'(r);
      w.out_col    = OUT_POS_W'(c);
      w.new_temp   = t;
      w.run_last   = run_last;
      w.sweep_done = done;
      return w;
   endfunction

   // Queue the words that one accepted cell causes: the cell above it, and in
   // the last row the cell itself as well.
   function automatic void predict_heat_words(input logic [TEMP_BITS-1:0] temp_in);
      int                   nr;
      int                   nc;
      int                   r;
      int                   c;
      bit                   last_row;
      bit                   row_end;
      logic [TEMP_BITS-1:0] t;
      logic [TEMP_BITS-1:0] west;
      logic [SUM_W-1:0]     sum;
      nr       = clamp_dim(rows_reg, MAX_ROWS);
      nc       = clamp_dim(cols_reg, MAX_COLS);
      r        = next_row;
      c        = next_col;
      last_row = (r == nr - 1);
      row_end  = (c + 1 >= nc);
      if (r >= 1) begin
         if (!boundary_temp(r - 1, c, nr, nc, t)) begin
            // north sits in the bank that this row is about to overwrite
            west = (c >= 1) ? bank_read(r - 1, c - 1) : '0;
            sum  = SUM_W'(bank_read(r, c)) + SUM_W'(west) + SUM_W'(bank_read(r - 1, c + 1))
                 + SUM_W'(temp_in);
            t    = sum[SUM_W-1:2];
         end
         expected_cells.push_back(heat_word(r - 1, c, t, !last_row, 1'b0));
      end
      if (c < MAX_COLS) heat_bank[r & 1][c] = temp_in;
      if (last_row) begin
         if (!boundary_temp(r, c, nr, nc, t)) t = edge_row_reg;
         expected_cells.push_back(heat_word(r, c, t, 1'b1, row_end));
      end
      if (row_end) begin
         next_col = 0;
         next_row = (r + 1 >= nr) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endfunction

   // -----------------------------------------------------------------------
   // result checking: every accepted word against the oldest expectation
   // -----------------------------------------------------------------------
   res_type owed;

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            $error("rsp word with nothing owed: row %0d col %0d", rsp_out_row, rsp_out_col);
            error_count++;
         end else begin
            owed = expected_cells.pop_front();
            words_checked++;
            check_field("out_row", 32'(owed.out_row), 32'(rsp_out_row));
            check_field("out_col", 32'(owed.out_col), 32'(rsp_out_col));
            check_field("new_temp", 32'(owed.new_temp), 32'(rsp_new_temp));
            check_field("run_last", 32'(owed.run_last), 32'(rsp_run_last));
            check_field("sweep_done", 32'(owed.sweep_done), 32'(rsp_sweep_done));
         end
         if (rsp_sweep_done) sweeps_seen++;
      end
   end

   // -----------------------------------------------------------------------
   // watchdog: count cycles without any handshake and give up at the limit
   // -----------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d words still owed",
                  idle_cycles, expected_cells.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -----------------------------------------------------------------------
   // receiver: stall on its own changing pattern, or hold off for a long
   // stretch on request, counting the cycles here
   // -----------------------------------------------------------------------
   stall_pattern_type stall_pattern = STALL_NONE;
   int                pattern_left  = 0;
   int                stall_period  = 2;
   int                stall_phase   = 0;
   int                hold_left     = 0;

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         // pick a fresh pattern now and then so stalls land on every phase
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(20, 200);
            stall_period  = $urandom_range(2, 7);
         end
         pattern_left--;
         stall_phase++;
         case (stall_pattern)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_phase % stall_period) == 0);
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // shared driving tasks; all are entered and left at a falling edge
   // -----------------------------------------------------------------------

   // Offer one cell word and hold it until accepted. Unless the sender is
   // steady, drop valid for a random gap whenever a burst runs out.
   task automatic send_temp(input logic [TEMP_BITS-1:0] t);
      int gap;
      if (!sender_steady && burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid     <= 1'b1;
      req_cell_temp <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_heat_words(t);
      cells_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed word, then let the pipeline settle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Write one register; the shadow copy follows once the edge has passed.
   task automatic put_csr(input csr_index_type idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CSR_DATA_W'(value);
      @(negedge clock);
      case (idx)
         CSR_GRID_ROWS:     rows_reg     = CFG_SIZE_W'(value);
         CSR_GRID_COLS:     cols_reg     = CFG_SIZE_W'(value);
         CSR_EDGE_ROW_TEMP: edge_row_reg = TEMP_BITS'(value);
         CSR_SIDE_TEMP:     side_reg     = TEMP_BITS'(value);
         CSR_POST_TEMP:     post_reg     = TEMP_BITS'(value);
         default: ;
      endcase
   endtask

   task automatic configure_sizes(input int unsigned rows, input int unsigned cols);
      put_csr(CSR_GRID_ROWS, rows);
      put_csr(CSR_GRID_COLS, cols);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure_grid(input int unsigned rows, input int unsigned cols,
                                 input logic [TEMP_BITS-1:0] row_edge,
                                 input logic [TEMP_BITS-1:0] side,
                                 input logic [TEMP_BITS-1:0] post);
      put_csr(CSR_GRID_ROWS, rows);
      put_csr(CSR_GRID_COLS, cols);
      put_csr(CSR_EDGE_ROW_TEMP, row_edge);
      put_csr(CSR_SIDE_TEMP, side);
      put_csr(CSR_POST_TEMP, post);
      csr_write_en <= 1'b0;
   endtask

   // bias towards the extremes so the stencil sum overflows sixteen bits
   function automatic logic [TEMP_BITS-1:0] pick_temp();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return TEMP_BITS'($urandom);
      endcase
   endfunction

   function automatic int sweep_length();
      return clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
   endfunction

   // one whole lattice of random temperatures, from the first cell
   task automatic run_sweep();
      int total;
      total = sweep_length();
      repeat (total) send_temp(pick_temp());
   endtask

   // -----------------------------------------------------------------------
   // tests
   // -----------------------------------------------------------------------

   // Single-cell lattices from zero sizes, then a three by four lattice, both
   // under the reset temperatures: row 0 returns nothing, the last row two
   // words per cell, a one-row lattice one word per cell.
   task automatic test_directed();
      logic [TEMP_BITS-1:0] corner_temps [12];
      corner_temps = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000, 16'h0001,
                       16'h7FFF, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h1234, 16'hEDCB};
      configure_sizes(0, 0);
      send_temp('1);
      send_temp('0);
      quiesce();
      configure_sizes(3, 4);
      foreach (corner_temps[i]) send_temp(corner_temps[i]);
      quiesce();
   endtask

   // Widest row and tallest column (both through the clamp above the
   // maximum), each run part way; then shrink the lattice to one cell so the
   // counters, now past the size, wrap back to the start on the next cell.
   task automatic test_size_limits();
      configure_grid(1, 2047, 16'hFFFF, 16'h0000, 16'h8001);
      repeat (PARTIAL_CELLS) send_temp(pick_temp());
      quiesce();
      configure_sizes(1, 1);
      send_temp(pick_temp());
      quiesce();
      configure_grid(2047, 0, 16'h0000, 16'hFFFF, 16'h7FFE);
      sender_steady = 1'b1;
      repeat (PARTIAL_CELLS) send_temp(pick_temp());
      sender_steady = 1'b0;
      quiesce();
      configure_sizes(1, 1);
      send_temp(pick_temp());
      quiesce();
   endtask

   // Pause mid-sweep until the queue is empty, then hold the receiver off
   // for a long stretch while the sender keeps offering, so the result queue
   // fills and req_stall must rise.
   task automatic test_back_pressure();
      int total;
      configure_grid(20, 5, pick_temp(), pick_temp(), pick_temp());
      total         = sweep_length();
      sender_steady = 1'b1;
      repeat (total / 2) send_temp(pick_temp());
      quiesce();
      hold_request = HOLD_CYCLES;
      repeat (total - total / 2) send_temp(pick_temp());
      sender_steady = 1'b0;
      quiesce();
   endtask

   // Random sweeps: tall and narrow, short and wide, or tiny lattices, each
   // with fresh temperatures and its own sender pacing.
   task automatic test_random_sweeps();
      int unsigned rows;
      int unsigned cols;
      int          len;
      while (random_cells < RANDOM_CELLS) begin
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               rows = $urandom_range(20, 36);
               cols = $urandom_range(2, 8);
            end
            3, 4: begin
               rows = $urandom_range(2, 8);
               cols = $urandom_range(20, 36);
            end
            default: begin
               rows = $urandom_range(0, 3);
               cols = $urandom_range(0, 3);
            end
         endcase
         len = clamp_dim(CFG_SIZE_W'(rows), MAX_ROWS) * clamp_dim(CFG_SIZE_W'(cols), MAX_COLS);
         // trim the last lattice to a single row that uses up the budget
         if (random_cells + len > RANDOM_CELLS) begin
            rows = 1;
            cols = unsigned'(RANDOM_CELLS - random_cells);
         end
         configure_grid(rows, cols, pick_temp(), pick_temp(), pick_temp());
         sender_steady = ($urandom_range(0, 3) == 0);
         random_cells += sweep_length();
         run_sweep();
         quiesce();
      end
      sender_steady = 1'b0;
   endtask

   // -----------------------------------------------------------------------
   // sequence
   // -----------------------------------------------------------------------
   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_size_limits();
      test_back_pressure();
      test_random_sweeps();

      quiesce();
      repeat (16) @(negedge clock);
      $display("Sent %0d cells and checked %0d new-cell words over %0d completed sweeps.",
               cells_sent, words_checked, sweeps_seen);
      $display("Covered zero and oversized sizes, mid-sweep shrinks, bursts, stalls, a hold-off.");
      if (error_count == 0 && expected_cells.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
